@@ rtl/dpy_pkg.sv @@
// Package for the direction to pitch/yaw converter.
// Holds the word types, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package dpy_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int IN_W    = 32;
    localparam int GUARD_W = 16;
    localparam int VEC_W   = 56;
    localparam int ANG_W   = 32;
    localparam int DEG_W   = 25;
    localparam int PROD_W  = 64;
    localparam int GAIN_SHIFT = 30 - GUARD_W;
    localparam int TAB_LEN = 32;

    localparam logic [31:0] GAIN_Q30  = 32'd1768195363;
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic signed [IN_W-1:0] dir_x;
        logic signed [IN_W-1:0] dir_y;
        logic signed [IN_W-1:0] dir_z;
    } vec_word_t;

    typedef struct packed {
        logic [DEG_W-1:0] pitch_deg;
        logic [DEG_W-1:0] yaw_deg;
    } ang_word_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANG_W-1:0]        a;
    } cordic_vec_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] py;
        logic [ANG_W-1:0]        yaw;
        logic                    special;
        logic                    zpos;
    } side_t;

endpackage

@@ rtl/dpy_cordic_stage.sv @@
// One registered CORDIC vectoring iteration with a fixed shift.
// Depends on dpy_pkg.
module dpy_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid,
    input  dpy_pkg::cordic_vec_t vin,
    output logic                valid_reg,
    output dpy_pkg::cordic_vec_t vout_reg
);

    dpy_pkg::cordic_vec_t vout_next;
    logic signed [dpy_pkg::VEC_W-1:0] dx;
    logic signed [dpy_pkg::VEC_W-1:0] dy;

    always_comb
    begin
        dx = vin.y >>> STEP;
        dy = vin.x >>> STEP;
        if (vin.y < 0)
        begin
            vout_next.x = vin.x - dx;
            vout_next.y = vin.y + dy;
            vout_next.a = vin.a - dpy_pkg::ATAN_TAB[STEP];
        end
        else
        begin
            vout_next.x = vin.x + dx;
            vout_next.y = vin.y - dy;
            vout_next.a = vin.a + dpy_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vout_reg <= vout_next;
    end

endmodule

@@ rtl/dpy_deg_stage.sv @@
// Output stage: binary angles to rounded degrees, plus the zero-horizontal case.
// Depends on dpy_pkg.
module dpy_deg_stage #(
    parameter int FRAC_BITS = dpy_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid,
    input  logic [dpy_pkg::ANG_W-1:0] pitch_a,
    input  dpy_pkg::side_t         side,
    output logic                   valid_reg,
    output dpy_pkg::ang_word_t     word_reg
);

    localparam int V_W = dpy_pkg::ANG_W + 10;
    localparam logic [V_W-1:0] FULL = V_W'(360) << FRAC_BITS;
    localparam logic [V_W-1:0] HALF = V_W'(1) << (31 - FRAC_BITS);
    localparam logic [V_W-1:0] PITCH_UP   = V_W'(270) << FRAC_BITS;
    localparam logic [V_W-1:0] PITCH_DOWN = V_W'(90) << FRAC_BITS;

    dpy_pkg::ang_word_t word_next;

    function automatic logic [dpy_pkg::DEG_W-1:0] to_deg(input logic [dpy_pkg::ANG_W-1:0] a);
        logic [V_W-1:0] v;
        v = V_W'(a) * V_W'(360);
        v = (v + HALF) >> (32 - FRAC_BITS);
        if (v >= FULL)
            v = v - FULL;
        return v[dpy_pkg::DEG_W-1:0];
    endfunction

    always_comb
    begin
        if (side.special)
        begin
            word_next.pitch_deg = side.zpos ? PITCH_UP[dpy_pkg::DEG_W-1:0]
                                            : PITCH_DOWN[dpy_pkg::DEG_W-1:0];
            word_next.yaw_deg   = '0;
        end
        else
        begin
            word_next.pitch_deg = to_deg(pitch_a);
            word_next.yaw_deg   = to_deg(side.yaw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

endmodule

@@ rtl/direction_to_pitch_yaw.sv @@
// Top level of the direction to pitch/yaw converter.
// Depends on dpy_pkg, dpy_cordic_stage and dpy_deg_stage.
//
//   channel | valid     | stall     | word
//   input   | vec_valid | vec_stall | vec (dir_x, dir_y, dir_z)
//   output  | ang_valid | ang_stall | ang (pitch_deg, yaw_deg)
//
// A word passes 2*CORDIC_STEPS + 3 register stages: an input register, a
// preparation stage with the gain multiply, one stage per CORDIC iteration for
// yaw and again for pitch, and the degree conversion.
// One word can enter every cycle while vec_stall is low.
// Reset clears only the valid bits. When the output word is held by
// ang_stall, the whole pipeline freezes and vec_stall is raised.
module direction_to_pitch_yaw #(
    parameter int CORDIC_STEPS = dpy_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = dpy_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vec_valid,
    output logic               vec_stall,
    input  dpy_pkg::vec_word_t vec,
    output logic               ang_valid,
    input  logic               ang_stall,
    output dpy_pkg::ang_word_t ang
);

    localparam int NST = 2 * CORDIC_STEPS;
    localparam int VW  = dpy_pkg::VEC_W;

    // Global advance: everything moves unless the output word is held.
    logic en;
    assign en = !(ang_valid && ang_stall);
    assign vec_stall = !en;

    // Input register.
    logic               a_valid_reg;
    dpy_pkg::vec_word_t a_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= vec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_word_reg <= vec;
    end

    // Preparation: scale x and y by the guard bits, fold a negative x by a
    // half turn, and start the product of |z| and the CORDIC gain.
    logic signed [VW-1:0]              xs, ys;
    logic [dpy_pkg::IN_W-1:0]          zmag;
    logic                              b_valid_reg;
    dpy_pkg::cordic_vec_t              b_vec_reg, b_vec_next;
    logic [dpy_pkg::PROD_W-1:0]        b_prod_reg, b_prod_next;
    logic                              b_special_reg, b_zpos_reg;

    always_comb
    begin
        xs = VW'(a_word_reg.dir_x) <<< dpy_pkg::GUARD_W;
        ys = VW'(a_word_reg.dir_y) <<< dpy_pkg::GUARD_W;
        if (a_word_reg.dir_x < 0)
        begin
            b_vec_next.x = -xs;
            b_vec_next.y = -ys;
            b_vec_next.a = dpy_pkg::HALF_TURN;
        end
        else
        begin
            b_vec_next.x = xs;
            b_vec_next.y = ys;
            b_vec_next.a = '0;
        end
        zmag = (a_word_reg.dir_z < 0) ? -a_word_reg.dir_z : a_word_reg.dir_z;
        b_prod_next = dpy_pkg::PROD_W'(zmag) * dpy_pkg::PROD_W'(dpy_pkg::GAIN_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_vec_reg     <= b_vec_next;
            b_prod_reg    <= b_prod_next;
            b_special_reg <= (a_word_reg.dir_x == 0) && (a_word_reg.dir_y == 0);
            b_zpos_reg    <= a_word_reg.dir_z > 0;
        end
    end

    // Scaled z, negated for upward vectors, becomes the pitch pass's y.
    logic signed [VW-1:0] zs;
    assign zs = VW'(b_prod_reg >> dpy_pkg::GAIN_SHIFT);

    // CORDIC chain: the first half finds yaw, the second half pitch.
    // Side data rides along in one register per stage.
    dpy_pkg::cordic_vec_t vec_c [0:NST];
    dpy_pkg::cordic_vec_t vin_c [0:NST-1];
    dpy_pkg::side_t       side_c [0:NST];
    logic                 valid_c [0:NST];

    assign vec_c[0]   = b_vec_reg;
    assign valid_c[0] = b_valid_reg;
    assign side_c[0]  = '{py:      (b_zpos_reg ? -zs : zs),
                          yaw:     '0,
                          special: b_special_reg,
                          zpos:    b_zpos_reg};

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        dpy_pkg::side_t side_reg;
        dpy_pkg::side_t side_next;

        if (k == CORDIC_STEPS)
        begin : g_turn
            // Pitch starts from the horizontal length left by the yaw pass.
            assign vin_c[k].x = vec_c[k].x;
            assign vin_c[k].y = side_c[k].py;
            assign vin_c[k].a = '0;
            always_comb
            begin
                side_next     = side_c[k];
                side_next.yaw = vec_c[k].a;
            end
        end
        else
        begin : g_pass
            assign vin_c[k]  = vec_c[k];
            assign side_next = side_c[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg <= side_next;
        end
        assign side_c[k+1] = side_reg;

        dpy_cordic_stage #(
            .STEP(k % CORDIC_STEPS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid    (valid_c[k]),
            .vin      (vin_c[k]),
            .valid_reg(valid_c[k+1]),
            .vout_reg (vec_c[k+1])
        );
    end

    dpy_deg_stage #(
        .FRAC_BITS(FRAC_BITS)
    ) u_deg (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid    (valid_c[NST]),
        .pitch_a  (vec_c[NST].a),
        .side     (side_c[NST]),
        .valid_reg(ang_valid),
        .word_reg (ang)
    );

    // A vector with no horizontal part leaves with a yaw of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_c[NST] && side_c[NST].special) |=> (ang.yaw_deg == '0))
    else $error("yaw not zero for a vertical vector");

    // A held output word keeps the pipeline frozen, checked on the preparation and last CORDIC valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ang_valid && ang_stall) |=> ($stable(valid_c[NST]) && $stable(b_valid_reg)))
    else $error("pipeline moved while output held");

    // Taking an input word while stalled would lose it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ang_valid && ang_stall) |-> vec_stall)
    else $error("input accepted while output held");

endmodule
